// File: hw/rtl/set_assoc_cache_access_model_assert.svh
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_CACHE_ACCESS_MODEL_ASSERT_SVH
`define SET_ASSOC_CACHE_ACCESS_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
`define SACM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SACM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SACM_ASSERT(label, clk, rst_n, prop, msg)
`define SACM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: hw/rtl/sacm_pkg.sv
// Types and constants shared by the cache model modules.
`default_nettype none
package sacm_pkg;
	typedef struct packed {
		logic        action;
		logic [7:0]  set_index;
		logic [31:0] tag;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [17:0] access_cycles;
		logic        dirty_writeback;
	} rsp_t;

	typedef struct packed {
		logic store_alloc;
		logic write_back;
		logic use_fifo;
		logic [12:0] block_bytes;
	} cfg_t;

	localparam logic [1:0] REG_STORE_ALLOC    = 2'd0;
	localparam logic [1:0] REG_WRITE_BACK     = 2'd1;
	localparam logic [1:0] REG_USE_FIFO       = 2'd2;
	localparam logic [1:0] REG_BLOCK_BYTES    = 2'd3;

	localparam logic [17:0] CACHE_CYCLES     = 18'd1;
	localparam logic [17:0] WRITE_MEM_CYCLES = 18'd100;
	localparam logic [12:0] BLOCK_MIN        = 13'd4;
	localparam logic [12:0] BLOCK_MAX        = 13'd4096;
	localparam int          QUEUE_DEPTH      = 2;
endpackage
`default_nettype wire

// File: hw/rtl/sacm_front.sv
// Front end: set reduction and request queue.
`default_nettype none
`include "set_assoc_cache_access_model_assert.svh"
module sacm_front #(
	parameter int SET_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire sacm_pkg::req_t   req,
	output logic                  q_valid,
	input  wire logic             q_take,
	output logic                  q_action,
	output logic [SET_W-1:0]      q_set,
	output logic [31:0]           q_tag
);
	import sacm_pkg::*;

	localparam int N = QUEUE_DEPTH;
	localparam int PW = (N > 1) ? $clog2(N) : 1;

	logic [N-1:0]            act_q;
	logic [SET_W-1:0]        set_q [N];
	logic [31:0]             tag_q [N];
	logic [PW-1:0]           wr_q, rd_q;
	logic [PW:0]             cnt_q;
	logic                    do_push, do_pop;
	logic [SET_W-1:0]        set_red;

	// Sets are a power of two here, so reduction keeps the low index bits.
	assign set_red  = SET_W'(req.set_index);
	assign full     = (cnt_q == (PW+1)'(N));
	assign do_push  = push && !full;
	assign do_pop   = q_take && q_valid;
	assign q_valid  = (cnt_q != '0);
	assign q_action = act_q[rd_q];
	assign q_set    = set_q[rd_q];
	assign q_tag    = tag_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(N-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(N-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			act_q[wr_q] <= req.action;
			set_q[wr_q] <= set_red;
			tag_q[wr_q] <= req.tag;
		end
	end

	`SACM_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= (PW+1)'(N), "queue count overflow")
	`SACM_ASSERT_NEXT(a_full_no_pop, clk, arst_n, full && !do_pop, full, "full dropped w/o pop")
	`SACM_ASSERT_NEXT(a_empty_push, clk, arst_n, !q_valid && do_push, q_valid, "push lost")
endmodule
`default_nettype wire

// File: hw/rtl/sacm_back.sv
// Back end: set memory read-modify-write, victim choice and cost.
`default_nettype none
`include "set_assoc_cache_access_model_assert.svh"
module sacm_back #(
	parameter int SET_W = 8,
	parameter int WAYS  = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sacm_pkg::cfg_t   cfg,
	input  wire logic             q_valid,
	output logic                  q_take,
	input  wire logic             q_action,
	input  wire logic [SET_W-1:0] q_set,
	input  wire logic [31:0]      q_tag,
	output logic                  empty,
	input  wire logic             pop,
	output sacm_pkg::rsp_t        rsp
);
	import sacm_pkg::*;

	localparam int SETS = 1 << SET_W;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	logic [SET_W-1:0] clr_q;
	logic        vld_mem [WAYS][SETS];
	logic        dty_mem [WAYS][SETS];
	logic [31:0] tag_mem [WAYS][SETS];
	logic [31:0] use_mem [WAYS][SETS];
	logic [31:0] ld_mem  [WAYS][SETS];
	logic        vld_s2 [WAYS];
	logic        dty_s2 [WAYS];
	logic [31:0] tag_s2 [WAYS];
	logic [31:0] use_s2 [WAYS];
	logic [31:0] ld_s2  [WAYS];
	logic [SET_W-1:0] set_s2;
	logic [31:0] tagin_s2;
	logic        act_s2;
	logic [31:0] ctr_q;
	logic        out_v_q;
	rsp_t        out_q;

	logic          hit;
	logic [WW-1:0] hway, inv_way, lru_way, vway;
	logic          any_inv;
	logic [31:0]   minv, st;
	logic          alloc, wb, wr_line, mark_dirty;
	logic [12:0]   bb;
	logic [17:0]   xfer, cyc;

	assign q_take = (state_q == ST_IDLE) && q_valid && (!out_v_q || pop);
	assign empty  = !out_v_q;
	assign rsp    = out_q;

	always_ff @(posedge clk) begin
		if (q_take) begin
			for (int w = 0; w < WAYS; w++) begin
				vld_s2[w] <= vld_mem[w][q_set];
				dty_s2[w] <= dty_mem[w][q_set];
				tag_s2[w] <= tag_mem[w][q_set];
				use_s2[w] <= use_mem[w][q_set];
				ld_s2[w]  <= ld_mem[w][q_set];
			end
			set_s2   <= q_set;
			tagin_s2 <= q_tag;
			act_s2   <= q_action;
		end
	end

	always_comb begin
		hit = 1'b0;
		hway = '0;
		any_inv = 1'b0;
		inv_way = '0;
		for (int w = WAYS-1; w >= 0; w--) begin
			if (vld_s2[w] && tag_s2[w] == tagin_s2) begin
				hit = 1'b1;
				hway = WW'(w);
			end
			if (!vld_s2[w]) begin
				any_inv = 1'b1;
				inv_way = WW'(w);
			end
		end
		lru_way = '0;
		st = '0;
		minv = cfg.use_fifo ? ld_s2[0] : use_s2[0];
		for (int w = 1; w < WAYS; w++) begin
			st = cfg.use_fifo ? ld_s2[w] : use_s2[w];
			if (st < minv) begin
				minv = st;
				lru_way = WW'(w);
			end
		end
		vway = any_inv ? inv_way : lru_way;
		bb = (cfg.block_bytes < BLOCK_MIN) ? BLOCK_MIN :
			(cfg.block_bytes > BLOCK_MAX) ? BLOCK_MAX : cfg.block_bytes;
		xfer = 18'(bb) * 18'd25;
		alloc = !hit && !(act_s2 && !cfg.store_alloc && !cfg.write_back);
		wb = alloc && vld_s2[vway] && cfg.write_back && dty_s2[vway];
		wr_line = hit || alloc;
		mark_dirty = act_s2 && cfg.write_back;
		if (hit) begin
			cyc = (act_s2 && !cfg.write_back) ? WRITE_MEM_CYCLES : CACHE_CYCLES;
		end else if (!alloc) begin
			cyc = WRITE_MEM_CYCLES;
		end else begin
			cyc = xfer + (wb ? xfer : 18'd0) +
				(act_s2 ? (cfg.write_back ? CACHE_CYCLES : WRITE_MEM_CYCLES) : 18'd0);
		end
	end

	// The clearing pass zeroes one set of valid and dirty bits per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			for (int w = 0; w < WAYS; w++) begin
				vld_mem[w][clr_q] <= 1'b0;
				dty_mem[w][clr_q] <= 1'b0;
			end
		end else if (state_q == ST_EXEC) begin
			if (hit) begin
				use_mem[hway][set_s2] <= ctr_q;
				if (mark_dirty) dty_mem[hway][set_s2] <= 1'b1;
			end else if (wr_line) begin
				vld_mem[vway][set_s2] <= 1'b1;
				dty_mem[vway][set_s2] <= mark_dirty;
				tag_mem[vway][set_s2] <= tagin_s2;
				use_mem[vway][set_s2] <= ctr_q;
				ld_mem[vway][set_s2]  <= ctr_q;
			end
			out_q.hit             <= hit;
			out_q.access_cycles   <= cyc;
			out_q.dirty_writeback <= wb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ctr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS-1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (pop) out_v_q <= 1'b0;
					if (q_take) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					out_v_q <= 1'b1;
					ctr_q   <= ctr_q + 32'd1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SACM_ASSERT_NEXT(a_take_exec, clk, arst_n, q_take, state_q == ST_EXEC, "take w/o exec")
	`SACM_ASSERT_NEXT(a_exec_out, clk, arst_n, state_q == ST_EXEC, out_v_q, "result lost")
	`SACM_ASSERT(a_wb_miss, clk, arst_n, !(state_q == ST_EXEC && wb && hit), "writeback on hit")
endmodule
`default_nettype wire

// File: hw/rtl/set_assoc_cache_access_model.sv
// Top level of the set-associative cache access model.
//
// Channel  | Handshake        | Payload
// input    | push / full      | req  (action, set_index, tag)
// result   | pop / empty      | rsp  (hit, access_cycles, dirty_writeback)
// config   | APB psel/penable | paddr, pwdata, prdata
//
// Each access takes two steps in the back end: one reads the set's ways from
// the line memories, the next compares, picks a victim and writes the set back.
// A result goes from the queue through the s2 registers into the output register
// when the back end is free, and the back end waits while a result has not been popped.
// A two-entry queue lets the front keep accepting while the back end stalls.
// After reset the back end clears the valid and dirty bits one set per cycle,
// through all SETS sets (256 by default); the queue fills and full rises meanwhile.
`default_nettype none
module set_assoc_cache_access_model #(
	parameter int SETS = 256,
	parameter int WAYS = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire sacm_pkg::req_t req,
	output logic                empty,
	input  wire logic           pop,
	output sacm_pkg::rsp_t      rsp,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import sacm_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

	cfg_t             cfg_q;
	logic             q_valid, q_take, q_action;
	logic [SET_W-1:0] q_set;
	logic [31:0]      q_tag;

	assign pready = 1'b1;

	// Registers are written at the access phase of an APB write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.store_alloc    <= 1'b1;
			cfg_q.write_back     <= 1'b1;
			cfg_q.use_fifo       <= 1'b0;
			cfg_q.block_bytes    <= 13'd16;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_STORE_ALLOC:    cfg_q.store_alloc    <= pwdata[0];
				REG_WRITE_BACK:     cfg_q.write_back     <= pwdata[0];
				REG_USE_FIFO:       cfg_q.use_fifo       <= pwdata[0];
				REG_BLOCK_BYTES:    cfg_q.block_bytes    <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_STORE_ALLOC:    prdata = {31'd0, cfg_q.store_alloc};
			REG_WRITE_BACK:     prdata = {31'd0, cfg_q.write_back};
			REG_USE_FIFO:       prdata = {31'd0, cfg_q.use_fifo};
			REG_BLOCK_BYTES:    prdata = {19'd0, cfg_q.block_bytes};
			default:            prdata = '0;
		endcase
	end

	sacm_front #(.SET_W(SET_W)) u_front (
		.clk, .arst_n, .push, .full, .req,
		.q_valid, .q_take, .q_action, .q_set, .q_tag
	);

	sacm_back #(.SET_W(SET_W), .WAYS(WAYS)) u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.q_valid, .q_take, .q_action, .q_set, .q_tag,
		.empty, .pop, .rsp
	);
endmodule
`default_nettype wire
